// ===== hw/rtl/gls_pkg.sv =====
// Shared constants, configuration struct and exp table for the Gaussian line renderer.
// No dependencies; every other file of the block imports this package.
package gls_pkg;

    localparam int COORD_BITS      = 12;
    localparam int PIXEL_BITS      = 16;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int EXP_RANGE    = 16;
    localparam int TAYLOR_TERMS = 12;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X     = 4'd0,
        REG_START_Y     = 4'd1,
        REG_END_X       = 4'd2,
        REG_END_Y       = 4'd3,
        REG_GAUSS_SCALE = 4'd4,
        REG_MARGIN_SQ   = 4'd5,
        REG_INV_LEN_SQ  = 4'd6,
        REG_AMPLITUDE   = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [17:0] start_x;
        logic signed [17:0] start_y;
        logic signed [17:0] end_x;
        logic signed [17:0] end_y;
        logic        [15:0] gauss_scale;
        logic        [23:0] margin_sq;
        logic        [31:0] inv_len_sq;
        logic signed [23:0] amplitude;
    } cfg_t;

    // datapath widths
    localparam int PX_W  = COORD_BITS + 4;
    localparam int PA_W  = ((PX_W > 17) ? PX_W : 17) + 2;
    localparam int BA_W  = 19;
    localparam int DOT_W = PA_W + BA_W + 1;
    localparam int U_W   = DOT_W - 1;
    localparam int SQ_W  = 2 * PA_W + 1;
    localparam int T_W   = 25;
    localparam int V_W   = ((PA_W > BA_W) ? PA_W : BA_W) + 2;
    localparam int NUM_W = (((PA_W + 24) > (26 + BA_W)) ? (PA_W + 24) : (26 + BA_W)) + 2;
    localparam int D2_W  = 2 * V_W + 1;
    localparam int X_W   = 40;
    localparam int Q_W   = X_W + $clog2(EXP_TABLE_DEPTH) + 1;
    localparam int EXP_W = 33;
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int W_W   = 17;
    localparam int SUM_W = 20;

    localparam int IN_TD_W  = ((2 * COORD_BITS + PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_TD_W = ((PIXEL_BITS + 7) / 8) * 8;

    typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

    // exp(-16k/depth) in Q32, step factor from a truncated Taylor sum
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t           tab;
        logic        [63:0] h;
        logic        [63:0] term;
        logic        [63:0] e;
        logic        [63:0] p;
        logic signed [63:0] sum;
        h    = (64'(EXP_RANGE) << 32) / 64'(EXP_TABLE_DEPTH);
        term = 64'd1 << 32;
        sum  = 64'sd1 <<< 32;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * h) >> 32) / 64'(n);
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        e = $unsigned(sum);
        tab[0] = EXP_W'(64'd1 << 32);
        for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
            p = {{(64-EXP_W){1'b0}}, tab[k-1]} * e + (64'd1 << 31);
            tab[k] = EXP_W'(p >> 32);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== hw/rtl/gls_cfg.sv =====
// Configuration register file of the Gaussian line renderer.
// Depends on gls_pkg for the register codes and the cfg_t struct.
module gls_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [gls_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output gls_pkg::cfg_t                      cfg
);
    import gls_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x     <= '0;
            cfg_reg.start_y     <= '0;
            cfg_reg.end_x       <= '0;
            cfg_reg.end_y       <= '0;
            cfg_reg.gauss_scale <= 16'd8192;
            cfg_reg.margin_sq   <= 24'd2304;
            cfg_reg.inv_len_sq  <= '0;
            cfg_reg.amplitude   <= 24'sd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_X:     cfg_reg.start_x     <= cfg_data[17:0];
                REG_START_Y:     cfg_reg.start_y     <= cfg_data[17:0];
                REG_END_X:       cfg_reg.end_x       <= cfg_data[17:0];
                REG_END_Y:       cfg_reg.end_y       <= cfg_data[17:0];
                REG_GAUSS_SCALE: cfg_reg.gauss_scale <= cfg_data[15:0];
                REG_MARGIN_SQ:   cfg_reg.margin_sq   <= cfg_data[23:0];
                REG_INV_LEN_SQ:  cfg_reg.inv_len_sq  <= cfg_data[31:0];
                REG_AMPLITUDE:   cfg_reg.amplitude   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/gls_dist.sv =====
// Squared pixel-to-segment distance pipeline, nine register stages.
// Depends on gls_pkg for widths and the cfg_t struct.
module gls_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  gls_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    input  logic [gls_pkg::COORD_BITS-1:0]    pix_x,
    input  logic [gls_pkg::COORD_BITS-1:0]    pix_y,
    input  logic [gls_pkg::PIXEL_BITS-1:0]    old_sample,
    output logic                              out_valid,
    output logic [23:0]                       d2,
    output logic                              in_margin,
    output logic [gls_pkg::PIXEL_BITS-1:0]    old_out
);
    import gls_pkg::*;

    localparam int NST = 9;

    logic                  vld_reg [NST];
    logic [PIXEL_BITS-1:0] old_reg [NST];

    logic [PX_W-1:0] px;
    logic [PX_W-1:0] py;

    logic signed [PA_W-1:0] s1_pax_reg, s1_pay_reg, s1_pbx_reg, s1_pby_reg;
    logic signed [BA_W-1:0] s1_bax_reg, s1_bay_reg;

    logic signed [PA_W+BA_W-1:0] s2_dx_reg, s2_dy_reg;
    logic        [2*PA_W-1:0]    s2_aax_reg, s2_aay_reg, s2_bbx_reg, s2_bby_reg;
    logic signed [PA_W-1:0]      s2_pax_reg, s2_pay_reg;
    logic signed [BA_W-1:0]      s2_bax_reg, s2_bay_reg;

    logic signed [DOT_W-1:0] s3_dot_reg;
    logic        [SQ_W-1:0]  s3_da_reg, s3_db_reg;
    logic signed [PA_W-1:0]  s3_pax_reg, s3_pay_reg;
    logic signed [BA_W-1:0]  s3_bax_reg, s3_bay_reg;

    logic                    s4_neg_reg;
    logic [U_W+15:0]         s4_hi_reg, s4_lo_reg;
    logic [SQ_W-1:0]         s4_da_reg, s4_db_reg;
    logic signed [PA_W-1:0]  s4_pax_reg, s4_pay_reg;
    logic signed [BA_W-1:0]  s4_bax_reg, s4_bay_reg;

    logic [U_W+16:0]         t24;
    logic                    s5_neg_reg, s5_tover_reg;
    logic [T_W-1:0]          s5_t_reg;
    logic [SQ_W-1:0]         s5_da_reg, s5_db_reg;
    logic signed [PA_W-1:0]  s5_pax_reg, s5_pay_reg;
    logic signed [BA_W-1:0]  s5_bax_reg, s5_bay_reg;

    logic                       s6_neg_reg, s6_tover_reg;
    logic signed [T_W+BA_W:0]   s6_tx_reg, s6_ty_reg;
    logic [SQ_W-1:0]            s6_da_reg, s6_db_reg;
    logic signed [PA_W-1:0]     s6_pax_reg, s6_pay_reg;

    logic signed [NUM_W-1:0] num_x, num_y;
    logic                    s7_neg_reg, s7_tover_reg;
    logic signed [V_W-1:0]   s7_vx_reg, s7_vy_reg;
    logic [SQ_W-1:0]         s7_da_reg, s7_db_reg;

    logic                    s8_neg_reg, s8_tover_reg;
    logic [2*V_W-1:0]        s8_sx_reg, s8_sy_reg;
    logic [SQ_W-1:0]         s8_da_reg, s8_db_reg;

    logic [D2_W-1:0] d2_full;
    logic [23:0]     s9_d2_reg;
    logic            s9_in_reg;

    assign px = {pix_x, 4'b0000};
    assign py = {pix_y, 4'b0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // t24 = floor(dot * inv_len_sq / 2^16), split into two 16-bit halves
    assign t24 = (U_W+17)'(s4_hi_reg) + (U_W+17)'(s4_lo_reg >> 16);

    // foot offset v = PA*2^24 - t*BA, rounded to 1/16 pixel
    assign num_x = (NUM_W'(s6_pax_reg) <<< 24) - NUM_W'(s6_tx_reg) + NUM_W'(1 << 23);
    assign num_y = (NUM_W'(s6_pay_reg) <<< 24) - NUM_W'(s6_ty_reg) + NUM_W'(1 << 23);

    always_comb
    begin
        if (s8_neg_reg)
            d2_full = D2_W'(s8_da_reg);
        else if (s8_tover_reg)
            d2_full = D2_W'(s8_db_reg);
        else
            d2_full = D2_W'(s8_sx_reg) + D2_W'(s8_sy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            old_reg[0] <= old_sample;
            for (int i = 1; i < NST; i++)
                old_reg[i] <= old_reg[i-1];

            s1_pax_reg <= PA_W'(signed'({1'b0, px})) - PA_W'(cfg.start_x);
            s1_pay_reg <= PA_W'(signed'({1'b0, py})) - PA_W'(cfg.start_y);
            s1_pbx_reg <= PA_W'(signed'({1'b0, px})) - PA_W'(cfg.end_x);
            s1_pby_reg <= PA_W'(signed'({1'b0, py})) - PA_W'(cfg.end_y);
            s1_bax_reg <= BA_W'(cfg.end_x) - BA_W'(cfg.start_x);
            s1_bay_reg <= BA_W'(cfg.end_y) - BA_W'(cfg.start_y);

            s2_dx_reg  <= s1_pax_reg * s1_bax_reg;
            s2_dy_reg  <= s1_pay_reg * s1_bay_reg;
            s2_aax_reg <= s1_pax_reg * s1_pax_reg;
            s2_aay_reg <= s1_pay_reg * s1_pay_reg;
            s2_bbx_reg <= s1_pbx_reg * s1_pbx_reg;
            s2_bby_reg <= s1_pby_reg * s1_pby_reg;
            s2_pax_reg <= s1_pax_reg;
            s2_pay_reg <= s1_pay_reg;
            s2_bax_reg <= s1_bax_reg;
            s2_bay_reg <= s1_bay_reg;

            s3_dot_reg <= DOT_W'(s2_dx_reg) + DOT_W'(s2_dy_reg);
            s3_da_reg  <= SQ_W'(s2_aax_reg) + SQ_W'(s2_aay_reg);
            s3_db_reg  <= SQ_W'(s2_bbx_reg) + SQ_W'(s2_bby_reg);
            s3_pax_reg <= s2_pax_reg;
            s3_pay_reg <= s2_pay_reg;
            s3_bax_reg <= s2_bax_reg;
            s3_bay_reg <= s2_bay_reg;

            s4_neg_reg <= s3_dot_reg[DOT_W-1];
            s4_hi_reg  <= s3_dot_reg[U_W-1:0] * cfg.inv_len_sq[31:16];
            s4_lo_reg  <= s3_dot_reg[U_W-1:0] * cfg.inv_len_sq[15:0];
            s4_da_reg  <= s3_da_reg;
            s4_db_reg  <= s3_db_reg;
            s4_pax_reg <= s3_pax_reg;
            s4_pay_reg <= s3_pay_reg;
            s4_bax_reg <= s3_bax_reg;
            s4_bay_reg <= s3_bay_reg;

            s5_neg_reg   <= s4_neg_reg;
            s5_tover_reg <= t24 > (U_W+17)'(1 << 24);
            s5_t_reg     <= t24[T_W-1:0];
            s5_da_reg    <= s4_da_reg;
            s5_db_reg    <= s4_db_reg;
            s5_pax_reg   <= s4_pax_reg;
            s5_pay_reg   <= s4_pay_reg;
            s5_bax_reg   <= s4_bax_reg;
            s5_bay_reg   <= s4_bay_reg;

            s6_neg_reg   <= s5_neg_reg;
            s6_tover_reg <= s5_tover_reg;
            s6_tx_reg    <= signed'({1'b0, s5_t_reg}) * s5_bax_reg;
            s6_ty_reg    <= signed'({1'b0, s5_t_reg}) * s5_bay_reg;
            s6_da_reg    <= s5_da_reg;
            s6_db_reg    <= s5_db_reg;
            s6_pax_reg   <= s5_pax_reg;
            s6_pay_reg   <= s5_pay_reg;

            s7_neg_reg   <= s6_neg_reg;
            s7_tover_reg <= s6_tover_reg;
            s7_vx_reg    <= num_x[24+V_W-1:24];
            s7_vy_reg    <= num_y[24+V_W-1:24];
            s7_da_reg    <= s6_da_reg;
            s7_db_reg    <= s6_db_reg;

            s8_neg_reg   <= s7_neg_reg;
            s8_tover_reg <= s7_tover_reg;
            s8_sx_reg    <= s7_vx_reg * s7_vx_reg;
            s8_sy_reg    <= s7_vy_reg * s7_vy_reg;
            s8_da_reg    <= s7_da_reg;
            s8_db_reg    <= s7_db_reg;

            s9_d2_reg <= d2_full[23:0];
            s9_in_reg <= d2_full <= D2_W'(cfg.margin_sq);
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign d2        = s9_d2_reg;
    assign in_margin = s9_in_reg;
    assign old_out   = old_reg[NST-1];

endmodule

// ===== hw/rtl/gls_weight.sv =====
// Gaussian weight from the exp table with linear interpolation, four register stages.
// Depends on gls_pkg for the table, widths and the cfg_t struct.
module gls_weight (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  gls_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    input  logic [23:0]                       d2,
    input  logic                              in_margin,
    input  logic [gls_pkg::PIXEL_BITS-1:0]    old_sample,
    output logic                              out_valid,
    output logic [gls_pkg::W_W-1:0]           weight,
    output logic                              inside_out,
    output logic [gls_pkg::PIXEL_BITS-1:0]    old_out
);
    import gls_pkg::*;

    localparam int NST   = 4;
    localparam int IDX_W = Q_W - 26;

    logic                  vld_reg [NST];
    logic                  in_reg  [NST];
    logic [PIXEL_BITS-1:0] old_reg [NST];

    logic [X_W-1:0] s1_x_reg;

    logic [Q_W-1:0]       q;
    logic [IDX_W-1:0]     idx_full;
    logic                 over;
    logic [EXP_IDX_W-1:0] ia;
    logic [EXP_IDX_W-1:0] ib;
    logic [EXP_W-1:0]     tab_a;
    logic [EXP_W-1:0]     tab_b;

    logic [EXP_W-1:0] s2_a_reg, s2_diff_reg;
    logic [15:0]      s2_frac_reg;
    logic             s2_over_reg;

    logic [EXP_W-1:0]    s3_a_reg;
    logic [EXP_W+15:0]   s3_m_reg;
    logic                s3_over_reg;

    logic [EXP_W-1:0] w32;
    logic [EXP_W:0]   w_round;
    logic [W_W-1:0]   s4_w_reg;

    assign q        = Q_W'(s1_x_reg) * Q_W'(EXP_TABLE_DEPTH);
    assign idx_full = q[Q_W-1:26];
    assign over     = idx_full >= IDX_W'(EXP_TABLE_DEPTH);
    assign ia       = over ? '0 : idx_full[EXP_IDX_W-1:0];
    assign ib       = ia + 1'b1;
    assign tab_a    = EXP_TAB[ia];
    assign tab_b    = EXP_TAB[ib];

    assign w32     = s3_a_reg - EXP_W'(s3_m_reg >> 16);
    assign w_round = (EXP_W+1)'(w32) + (EXP_W+1)'(1 << 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg[0]  <= in_margin;
            old_reg[0] <= old_sample;
            for (int i = 1; i < NST; i++)
            begin
                in_reg[i]  <= in_reg[i-1];
                old_reg[i] <= old_reg[i-1];
            end

            s1_x_reg <= d2 * cfg.gauss_scale;

            s2_a_reg    <= tab_a;
            s2_diff_reg <= tab_a - tab_b;
            s2_frac_reg <= q[25:10];
            s2_over_reg <= over;

            s3_a_reg    <= s2_a_reg;
            s3_m_reg    <= s2_diff_reg * s2_frac_reg;
            s3_over_reg <= s2_over_reg;

            // exponent past the table end gives zero weight
            s4_w_reg <= s3_over_reg ? '0 : w_round[EXP_W-1:16];
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign weight     = s4_w_reg;
    assign inside_out = in_reg[NST-1];
    assign old_out    = old_reg[NST-1];

endmodule

// ===== hw/rtl/gls_blend.sv =====
// Amplitude scaling, rounding and saturating add into the sample inside the margin; two register stages.
// Depends on gls_pkg for widths and the cfg_t struct.
module gls_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  gls_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    input  logic [gls_pkg::W_W-1:0]           weight,
    input  logic                              in_margin,
    input  logic [gls_pkg::PIXEL_BITS-1:0]    old_sample,
    output logic                              out_valid,
    output logic [gls_pkg::PIXEL_BITS-1:0]    new_sample,
    output logic                              inside_margin,
    output logic                              clipped
);
    import gls_pkg::*;

    localparam int P_W = 24 + W_W + 1;
    localparam logic signed [SUM_W-1:0] MAXV = SUM_W'((1 << PIXEL_BITS) - 1);

    logic                    s1_vld_reg;
    logic signed [P_W-1:0]   s1_p_reg;
    logic                    s1_in_reg;
    logic [PIXEL_BITS-1:0]   s1_old_reg;

    logic signed [P_W-1:0]   p_round;
    logic signed [SUM_W-1:0] sum;

    logic                  out_vld_reg;
    logic [PIXEL_BITS-1:0] new_reg;
    logic                  in_out_reg;
    logic                  clip_reg;

    assign p_round = s1_p_reg + P_W'(1 << 23);
    assign sum     = SUM_W'(signed'({1'b0, s1_old_reg}))
                   + SUM_W'(signed'(p_round[P_W-1:24]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg   <= cfg.amplitude * signed'({1'b0, weight});
            s1_in_reg  <= in_margin;
            s1_old_reg <= old_sample;

            in_out_reg <= s1_in_reg;
            if (!s1_in_reg)
            begin
                new_reg  <= s1_old_reg;
                clip_reg <= 1'b0;
            end
            else if (sum < 0)
            begin
                new_reg  <= '0;
                clip_reg <= 1'b1;
            end
            else if (sum > MAXV)
            begin
                new_reg  <= MAXV[PIXEL_BITS-1:0];
                clip_reg <= 1'b1;
            end
            else
            begin
                new_reg  <= sum[PIXEL_BITS-1:0];
                clip_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_vld_reg;
    assign new_sample    = new_reg;
    assign inside_margin = in_out_reg;
    assign clipped       = clip_reg;

endmodule

// ===== hw/rtl/gaussian_line_segment_render.sv =====
// Top level of the Gaussian line segment renderer: config registers and the pixel pipeline.
// Depends on gls_pkg, gls_cfg, gls_dist, gls_weight and gls_blend.
//
//  channel   direction  signals                         transaction
//  s_*       in         s_tvalid s_tready s_tdata       one pixel and its old sample
//  m_*       out        m_tvalid m_tready m_tdata m_tuser  one drawn sample
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// One pixel per cycle while the output is taken; 9 distance, 4 weight and 2 blend stages.
// The whole pipeline advances together and holds when the output is full and not taken.
// Reset clears all stage valid bits and loads register defaults; cfg_ready is always high.
module gaussian_line_segment_render (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pix_x, pix_y, old_sample, zero pad
    input  logic [gls_pkg::IN_TD_W-1:0]        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // new_sample, zero pad
    output logic [gls_pkg::OUT_TD_W-1:0]       m_tdata,
    // inside_margin, clipped
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [gls_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import gls_pkg::*;

    cfg_t cfg;
    logic en;

    logic                  d_valid, d_inside;
    logic [23:0]           d_d2;
    logic [PIXEL_BITS-1:0] d_old;

    logic                  w_valid, w_inside;
    logic [W_W-1:0]        w_weight;
    logic [PIXEL_BITS-1:0] w_old;

    logic [PIXEL_BITS-1:0] new_sample;
    logic                  inside_margin, clipped;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    gls_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gls_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .pix_x      (s_tdata[COORD_BITS-1:0]),
        .pix_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .old_sample (s_tdata[2*COORD_BITS+PIXEL_BITS-1:2*COORD_BITS]),
        .out_valid  (d_valid),
        .d2         (d_d2),
        .in_margin  (d_inside),
        .old_out    (d_old)
    );

    gls_weight u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg),
        .in_valid   (d_valid),
        .d2         (d_d2),
        .in_margin  (d_inside),
        .old_sample (d_old),
        .out_valid  (w_valid),
        .weight     (w_weight),
        .inside_out (w_inside),
        .old_out    (w_old)
    );

    gls_blend u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .cfg           (cfg),
        .in_valid      (w_valid),
        .weight        (w_weight),
        .in_margin     (w_inside),
        .old_sample    (w_old),
        .out_valid     (m_tvalid),
        .new_sample    (new_sample),
        .inside_margin (inside_margin),
        .clipped       (clipped)
    );

    assign m_tdata = OUT_TD_W'(new_sample);
    assign m_tuser = {clipped, inside_margin};

    a_clip_needs_inside : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && clipped |-> inside_margin)
        else $error("clipped set on a pixel outside the margin");

    a_clip_at_rail : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && clipped |-> (new_sample == '0 || new_sample == '1))
        else $error("clipped sample not at a rail");

    a_empty_after_reset : assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule
